FILE: src/assert_macros.svh
// Assertion helpers shared by the console writer modules.
// Each macro expects signals named clk and rst_n in the module that uses it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define TCNW_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// A condition that must never be seen outside reset.
`define TCNW_ASSERT_NEVER(lbl, cond, msg) \
    `TCNW_ASSERT(lbl, !(cond), msg)

`endif

FILE: src/tcnw_pkg.sv
`timescale 1ns / 1ps

package tcnw_pkg;

    // Default geometry and digit capacity.
    localparam int DEF_ROW_CELLS    = 80;
    localparam int DEF_SCREEN_CELLS = 2000;
    localparam int DEF_MAX_DIGITS   = 32;

    // Field widths fixed by the stream format.
    localparam int FUNC_W      = 2;
    localparam int CHAR_W      = 8;
    localparam int NUM_W       = 32;
    localparam int CELL_ADDR_W = 11;
    localparam int BASE_W      = 2;
    localparam int PAD_W       = 6;
    localparam int PADE_W      = 7;
    localparam int CFG_IDX_W   = 2;
    localparam int DIGIT_W     = 4;

    localparam int IN_DATA_W   = 40;
    localparam int OUT_DATA_W  = 24;

    // Item kinds carried in the input side-band.
    localparam logic [FUNC_W-1:0] FUNC_CHAR = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_NUM  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_PTR  = 2'd2;

    // Number base selector codes; the two unnamed codes print hexadecimal.
    localparam logic [BASE_W-1:0] BASE_BIN = 2'd0;
    localparam logic [BASE_W-1:0] BASE_DEC = 2'd1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_BASE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PAD  = 2'd1;

    // Control characters that only move the cursor.
    localparam logic [CHAR_W-1:0] CH_TAB = 8'h09;
    localparam logic [CHAR_W-1:0] CH_LF  = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_CR  = 8'h0D;

    localparam int TAB_STOP   = 4;
    localparam int TAB_BITS   = $clog2(TAB_STOP);
    localparam int PTR_DIGITS = 8;

    // A 32-bit value never needs more than 32 digits in any supported base.
    localparam int CONV_DIGITS = 32;
    localparam int BCD_DIGITS  = 10;
    localparam int HEX_DIGITS  = NUM_W / DIGIT_W;
    localparam int DD_CNT_W    = $clog2(NUM_W);

    typedef struct packed {
        logic capture;
        logic dd_step;
        logic load_digits;
        logic emit_char;
        logic move_ctrl;
        logic emit_digit;
        logic skip_digit;
    } tcnw_cmd_t;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic              is_dec;
        logic              is_ctrl_char;
        logic              slot_free;
        logic              dd_done;
        logic              idx_zero;
        logic              skip_digit;
    } tcnw_stat_t;

    // Digit value to its upper-case glyph.
    function automatic logic [CHAR_W-1:0] digit_glyph(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] g;
        if (d < DIGIT_W'(10))
            g = 8'h30 + {4'b0000, d};
        else
            g = 8'h37 + {4'b0000, d};
        return g;
    endfunction

endpackage

FILE: src/tcnw_ctrl.sv
`timescale 1ns / 1ps

module tcnw_ctrl
    import tcnw_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  tcnw_stat_t stat,
    output tcnw_cmd_t  cmd
);

`include "assert_macros.svh"

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_DISP = 3'd1;
    localparam logic [2:0] ST_CHAR = 3'd2;
    localparam logic [2:0] ST_CONV = 3'd3;
    localparam logic [2:0] ST_LOAD = 3'd4;
    localparam logic [2:0] ST_EMIT = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign s_tready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_DISP;
                end
            end
            ST_DISP:
            begin
                case (stat.func)
                    FUNC_CHAR: state_next = ST_CHAR;
                    FUNC_NUM,
                    FUNC_PTR:  state_next = stat.is_dec ? ST_CONV : ST_LOAD;
                    default:   state_next = ST_IDLE;
                endcase
            end
            ST_CHAR:
            begin
                if (stat.is_ctrl_char)
                begin
                    cmd.move_ctrl = 1'b1;
                    state_next    = ST_IDLE;
                end
                else if (stat.slot_free)
                begin
                    cmd.emit_char = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            ST_CONV:
            begin
                cmd.dd_step = 1'b1;
                if (stat.dd_done)
                    state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                cmd.load_digits = 1'b1;
                state_next      = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (stat.skip_digit)
                    cmd.skip_digit = 1'b1;
                else if (stat.slot_free)
                begin
                    cmd.emit_digit = 1'b1;
                    if (stat.idx_zero)
                        state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    `TCNW_ASSERT(a_cmd_onehot0, $onehot0(cmd), "more than one datapath command at once")
    `TCNW_ASSERT(a_conv_holds, (state_reg == ST_CONV && !stat.dd_done) |=> (state_reg == ST_CONV), "conversion left early")

endmodule

FILE: src/tcnw_dp.sv
`timescale 1ns / 1ps

module tcnw_dp
    import tcnw_pkg::*;
#(
    parameter int ROW_CELLS    = DEF_ROW_CELLS,
    parameter int SCREEN_CELLS = DEF_SCREEN_CELLS,
    parameter int MAX_DIGITS   = DEF_MAX_DIGITS
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  tcnw_cmd_t              cmd,
    output tcnw_stat_t             stat,
    input  logic [FUNC_W-1:0]      in_func,
    input  logic [CHAR_W-1:0]      in_char,
    input  logic [NUM_W-1:0]       in_number,
    input  logic                   cfg_we,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [PAD_W-1:0]       cfg_data,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [CELL_ADDR_W-1:0] out_addr,
    output logic [CHAR_W-1:0]      out_glyph,
    output logic                   out_last
);

`include "assert_macros.svh"

    localparam int CUR_W = $clog2(SCREEN_CELLS);
    localparam int COL_W = $clog2(ROW_CELLS);
    localparam int SUM_W = CUR_W + 9;
    localparam int IDX_W = $clog2(MAX_DIGITS);
    localparam int DIG_W = MAX_DIGITS * DIGIT_W;
    localparam int BCD_W = BCD_DIGITS * DIGIT_W;

    // Configuration.
    logic [BASE_W-1:0] base_reg;
    logic [PAD_W-1:0]  pad_reg;

    // Captured item.
    logic [FUNC_W-1:0] func_reg;
    logic [CHAR_W-1:0] char_reg;
    logic [NUM_W-1:0]  num_reg;
    logic              mode_dec_reg;
    logic              mode_bin_reg;
    logic [PADE_W-1:0] pad_eff_reg;

    // Binary to BCD conversion.
    logic [BCD_W-1:0]    bcd_reg;
    logic [BCD_W-1:0]    bcd_adj;
    logic [DD_CNT_W-1:0] dd_cnt_reg;

    // Digit shift line, most significant slot on top.
    logic [DIG_W-1:0]         digits_reg;
    logic [DIG_W-1:0]         digits_load;
    logic [IDX_W-1:0]         idx_reg;
    logic                     started_reg;
    logic [CONV_DIGITS-1:0]   ovf_bits;
    logic [DIGIT_W-1:0]       cand [CONV_DIGITS];
    logic [DIGIT_W-1:0]       top_digit;

    // Cursor and its column within the row.
    logic [CUR_W-1:0] cursor_reg;
    logic [CUR_W-1:0] cursor_next;
    logic [COL_W-1:0] col_reg;
    logic [COL_W-1:0] col_next;
    logic [SUM_W-1:0] adv_sum;
    logic [SUM_W-1:0] lf_sum;
    logic [SUM_W-1:0] tab_sum;
    logic [COL_W:0]   col_adv;
    logic [COL_W:0]   col_tab;
    logic [TAB_BITS:0] tab_step;

    // Output register.
    logic                   out_valid_reg;
    logic [CELL_ADDR_W-1:0] out_addr_reg;
    logic [CHAR_W-1:0]      out_glyph_reg;
    logic                   out_last_reg;
    logic                   slot_free;
    logic                   emit;

    assign slot_free = !out_valid_reg || out_ready;
    assign emit      = cmd.emit_char || cmd.emit_digit;
    assign top_digit = digits_reg[DIG_W-1 -: DIGIT_W];

    assign stat.func         = func_reg;
    assign stat.is_dec       = mode_dec_reg;
    assign stat.is_ctrl_char = (char_reg == CH_LF) || (char_reg == CH_TAB) || (char_reg == CH_CR);
    assign stat.slot_free    = slot_free;
    assign stat.dd_done      = (dd_cnt_reg == DD_CNT_W'(NUM_W - 1));
    assign stat.idx_zero     = (idx_reg == '0);
    assign stat.skip_digit   = !started_reg && (top_digit == '0)
                               && (PADE_W'(idx_reg) >= pad_eff_reg) && (idx_reg != '0);

    assign out_valid = out_valid_reg;
    assign out_addr  = out_addr_reg;
    assign out_glyph = out_glyph_reg;
    assign out_last  = out_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg <= BASE_DEC;
            pad_reg  <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_BASE: base_reg <= cfg_data[BASE_W-1:0];
                REG_PAD:  pad_reg  <= cfg_data;
                default:  ;
            endcase
        end
    end

    // Shift-add-3 adjustment of every BCD digit, then one bit shifted in.
    always_comb
    begin
        for (int i = 0; i < BCD_DIGITS; i++)
        begin
            if (bcd_reg[i*DIGIT_W +: DIGIT_W] >= DIGIT_W'(5))
                bcd_adj[i*DIGIT_W +: DIGIT_W] = bcd_reg[i*DIGIT_W +: DIGIT_W] + DIGIT_W'(3);
            else
                bcd_adj[i*DIGIT_W +: DIGIT_W] = bcd_reg[i*DIGIT_W +: DIGIT_W];
        end
    end

    // Digit candidates for the selected base, lowest digit first.
    always_comb
    begin
        for (int i = 0; i < CONV_DIGITS; i++)
        begin
            if (mode_bin_reg)
                cand[i] = {3'b000, num_reg[i]};
            else if (mode_dec_reg)
                cand[i] = (i < BCD_DIGITS) ? bcd_reg[(i % BCD_DIGITS)*DIGIT_W +: DIGIT_W] : '0;
            else
                cand[i] = (i < HEX_DIGITS) ? num_reg[(i % HEX_DIGITS)*DIGIT_W +: DIGIT_W] : '0;
            ovf_bits[i] = (i >= MAX_DIGITS) && (cand[i] != '0);
        end
        for (int j = 0; j < MAX_DIGITS; j++)
        begin
            if (j < CONV_DIGITS)
                digits_load[j*DIGIT_W +: DIGIT_W] = cand[j % CONV_DIGITS];
            else
                digits_load[j*DIGIT_W +: DIGIT_W] = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            func_reg     <= in_func;
            char_reg     <= in_char;
            num_reg      <= in_number;
            mode_dec_reg <= (in_func == FUNC_NUM) && (base_reg == BASE_DEC);
            mode_bin_reg <= (in_func == FUNC_NUM) && (base_reg == BASE_BIN);
            if (in_func == FUNC_PTR)
                pad_eff_reg <= PADE_W'(PTR_DIGITS);
            else if (PADE_W'(pad_reg) > PADE_W'(MAX_DIGITS))
                pad_eff_reg <= PADE_W'(MAX_DIGITS);
            else
                pad_eff_reg <= PADE_W'(pad_reg);
            bcd_reg      <= '0;
            dd_cnt_reg   <= '0;
        end
        else if (cmd.dd_step)
        begin
            bcd_reg    <= {bcd_adj[BCD_W-2:0], num_reg[NUM_W-1]};
            num_reg    <= {num_reg[NUM_W-2:0], 1'b0};
            dd_cnt_reg <= dd_cnt_reg + DD_CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_digits)
            digits_reg <= digits_load;
        else if (cmd.emit_digit || cmd.skip_digit)
            digits_reg <= {digits_reg[DIG_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg     <= '0;
            started_reg <= 1'b0;
        end
        else if (cmd.load_digits)
        begin
            idx_reg     <= IDX_W'(MAX_DIGITS - 1);
            started_reg <= |ovf_bits;
        end
        else if (cmd.emit_digit || cmd.skip_digit)
        begin
            idx_reg     <= idx_reg - IDX_W'(1);
            started_reg <= started_reg || cmd.emit_digit;
        end
    end

    // Cursor arithmetic. The column tracks cursor modulo the row width.
    always_comb
    begin
        adv_sum  = SUM_W'(cursor_reg) + SUM_W'(1);
        lf_sum   = SUM_W'(cursor_reg) + SUM_W'(ROW_CELLS) - SUM_W'(col_reg);
        tab_step = (TAB_BITS+1)'(TAB_STOP) - {1'b0, cursor_reg[TAB_BITS-1:0]};
        tab_sum  = SUM_W'(cursor_reg) + SUM_W'(tab_step);
        col_adv  = {1'b0, col_reg} + (COL_W+1)'(1);
        col_tab  = {1'b0, col_reg} + (COL_W+1)'(tab_step);
        if (col_tab >= (COL_W+1)'(ROW_CELLS))
            col_tab = col_tab - (COL_W+1)'(ROW_CELLS);

        cursor_next = cursor_reg;
        col_next    = col_reg;
        if (emit)
        begin
            if (adv_sum >= SUM_W'(SCREEN_CELLS))
            begin
                cursor_next = '0;
                col_next    = '0;
            end
            else
            begin
                cursor_next = CUR_W'(adv_sum);
                col_next    = (col_adv == (COL_W+1)'(ROW_CELLS)) ? '0 : COL_W'(col_adv);
            end
        end
        else if (cmd.move_ctrl)
        begin
            case (char_reg)
                CH_LF:
                begin
                    cursor_next = (lf_sum >= SUM_W'(SCREEN_CELLS)) ? '0 : CUR_W'(lf_sum);
                    col_next    = '0;
                end
                CH_TAB:
                begin
                    if (tab_sum >= SUM_W'(SCREEN_CELLS))
                    begin
                        cursor_next = '0;
                        col_next    = '0;
                    end
                    else
                    begin
                        cursor_next = CUR_W'(tab_sum);
                        col_next    = COL_W'(col_tab);
                    end
                end
                CH_CR:
                begin
                    cursor_next = cursor_reg - CUR_W'(col_reg);
                    col_next    = '0;
                end
                default:
                begin
                    cursor_next = cursor_reg;
                    col_next    = col_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_reg    <= '0;
            col_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cursor_reg <= cursor_next;
            col_reg    <= col_next;
            if (emit)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_addr_reg  <= CELL_ADDR_W'(cursor_reg);
            out_glyph_reg <= cmd.emit_char ? char_reg : digit_glyph(top_digit);
            out_last_reg  <= cmd.emit_char || (idx_reg == '0);
        end
    end

    `TCNW_ASSERT(a_cursor_range, {1'b0, cursor_reg} < (CUR_W+1)'(SCREEN_CELLS), "cursor past the screen")
    `TCNW_ASSERT(a_col_range, {1'b0, col_reg} < (COL_W+1)'(ROW_CELLS), "column past the row")
    `TCNW_ASSERT_NEVER(a_emit_busy, emit && !slot_free, "cell write while output register is full")

endmodule

FILE: src/text_console_number_writer_top.sv
`timescale 1ns / 1ps
// Channel  | Direction | Beat contents
// s_axis   | in        | tdata: char_in, number; tuser: func
// m_axis   | out       | tdata: cell_address, glyph; tlast: last_write
// cfg      | in        | cfg_index selects the register, cfg_data carries the value
//
// A character passes the dispatch and character states before its cell write (or cursor move).
// A number passes dispatch, the binary to BCD converter (decimal only), a digit load and the digit scan;
// the digit scan covers one slot per cycle while the output register can take a beat.
// Reset is asynchronous and active low; it homes the cursor and restores base ten, no padding.
// A stalled output holds the current beat in the output register and holds back further digit writes.
// Input is taken only between items; a finished beat may wait while the next item enters.

module text_console_number_writer_top
    import tcnw_pkg::*;
#(
    parameter int ROW_CELLS    = DEF_ROW_CELLS,
    parameter int SCREEN_CELLS = DEF_SCREEN_CELLS,
    parameter int MAX_DIGITS   = DEF_MAX_DIGITS
)
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // [7:0] char_in, [39:8] number
    input  logic [FUNC_W-1:0]     s_tuser,   // [1:0] func

    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // [10:0] cell_address, [18:11] glyph, rest zero
    output logic                  m_tlast,   // last_write

    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [PAD_W-1:0]      cfg_data
);

    tcnw_cmd_t              cmd;
    tcnw_stat_t             stat;
    logic [CELL_ADDR_W-1:0] cell_addr;
    logic [CHAR_W-1:0]      glyph;

    // Registers are written whenever asked; users change them only while idle (not enforced).
    assign cfg_ready = 1'b1;

    // The sequencer owns the input handshake and steps the datapath with at most one command per cycle.
    tcnw_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // The datapath holds the cursor, the configuration, the converter and the output register.
    tcnw_dp #(
        .ROW_CELLS    (ROW_CELLS),
        .SCREEN_CELLS (SCREEN_CELLS),
        .MAX_DIGITS   (MAX_DIGITS)
    ) u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .in_func   (s_tuser),
        .in_char   (s_tdata[CHAR_W-1:0]),
        .in_number (s_tdata[CHAR_W +: NUM_W]),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_addr  (cell_addr),
        .out_glyph (glyph),
        .out_last  (m_tlast)
    );

    // Pack the output beat, lowest field first, zero-filled to whole bytes.
    assign m_tdata = {{(OUT_DATA_W - CELL_ADDR_W - CHAR_W){1'b0}}, glyph, cell_addr};

endmodule

FILE: sim/text_console_number_writer_top_tb.sv
`timescale 1ns / 1ps

module text_console_number_writer_top_tb;
    import tcnw_pkg::*;

    // Codes that the package leaves unnamed.
    localparam logic [FUNC_W-1:0]    FUNC_UNUSED = 2'd3;
    localparam logic [BASE_W-1:0]    BASE_HEX    = 2'd2;
    localparam logic [BASE_W-1:0]    BASE_ALIAS  = 2'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE2  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE3  = 2'd3;

    // Quiet cycles waited after the last owed cell write, so that the writer
    // has gone idle.
    localparam int DRAIN_CYCLES  = 80;
    localparam int STALL_LIMIT   = 3000;
    localparam int SEG_ITEMS     = 27;
    localparam int SEGS_PER_PASS = 4;

    // One cell write: the address it lands on, the byte stored, and whether it
    // closes the input item that caused it.
    typedef struct {
        logic [CELL_ADDR_W-1:0] addr;
        logic [CHAR_W-1:0]      glyph;
        logic                   last;
    } cell_write_t;

    // Tracks the cursor and the two registers and keeps the cell writes that
    // are still owed by the block, oldest first.
    class console_scoreboard;
        int                cursor;
        logic [BASE_W-1:0] base_sel;
        logic [PAD_W-1:0]  pad_digits;
        cell_write_t       pending[$];
        string             glyph_set;

        function new();
            cursor     = 0;
            base_sel   = BASE_DEC;
            pad_digits = '0;
            glyph_set  = "0123456789ABCDEF";
        endfunction

        function int wrapped(int c);
            return (c >= DEF_SCREEN_CELLS) ? 0 : c;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [PAD_W-1:0] val);
            if (idx == REG_BASE)
                base_sel = val[BASE_W-1:0];
            else if (idx == REG_PAD)
                pad_digits = val;
        endfunction

        function void put_glyph(logic [CHAR_W-1:0] g, bit last);
            cell_write_t w;
            w.addr  = cursor[CELL_ADDR_W-1:0];
            w.glyph = g;
            w.last  = last;
            pending.push_back(w);
            cursor = wrapped(cursor + 1);
        endfunction

        function void print_number(logic [NUM_W-1:0] n, int unsigned radix,
                                   int unsigned min_digits);
            logic [DIGIT_W-1:0] digits[DEF_MAX_DIGITS];
            int                 count;
            int                 i;
            if (min_digits > DEF_MAX_DIGITS)
                min_digits = DEF_MAX_DIGITS;
            count = 0;
            do
            begin
                digits[count] = DIGIT_W'(n % radix);
                n = n / radix;
                count++;
            end
            while (n != 0 && count < DEF_MAX_DIGITS);
            while (count < min_digits)
            begin
                digits[count] = '0;
                count++;
            end
            for (i = count - 1; i >= 0; i--)
                put_glyph(glyph_set[digits[i]], i == 0);
        endfunction

        function void note_item(logic [FUNC_W-1:0] func, logic [CHAR_W-1:0] ch,
                                logic [NUM_W-1:0] num);
            int unsigned radix;
            case (func)
                FUNC_CHAR:
                begin
                    case (ch)
                        CH_LF:   cursor = wrapped(cursor + DEF_ROW_CELLS - cursor % DEF_ROW_CELLS);
                        CH_TAB:  cursor = wrapped(cursor + TAB_STOP - cursor % TAB_STOP);
                        CH_CR:   cursor = cursor - cursor % DEF_ROW_CELLS;
                        default: put_glyph(ch, 1'b1);
                    endcase
                end
                FUNC_NUM:
                begin
                    radix = (base_sel == BASE_BIN) ? 2 : (base_sel == BASE_DEC) ? 10 : 16;
                    print_number(num, radix, pad_digits);
                end
                FUNC_PTR:
                    print_number(num, 16, PTR_DIGITS);
                default:
                    ;
            endcase
        endfunction

        // Compares one cell write with the oldest expectation, which the caller
        // has made sure exists.
        function bit check_write(logic [CELL_ADDR_W-1:0] addr, logic [CHAR_W-1:0] glyph,
                                 logic last, output string detail);
            cell_write_t w;
            w = pending.pop_front();
            detail = "";
            if (addr !== w.addr)
                detail = {detail, $sformatf(" cell_address %0d, expected %0d", addr, w.addr)};
            if (glyph !== w.glyph)
                detail = {detail, $sformatf(" glyph %02h, expected %02h", glyph, w.glyph)};
            if (last !== w.last)
                detail = {detail, $sformatf(" last_write %0b, expected %0b", last, w.last)};
            return detail == "";
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;    // [7:0] char_in, [39:8] number
    logic [FUNC_W-1:0]     s_tuser;    // [1:0] func
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;    // [10:0] cell_address, [18:11] glyph, rest zero
    logic                  m_tlast;    // last_write
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [PAD_W-1:0]      cfg_data;

    console_scoreboard sb;
    int                err_count;
    int                quiet_cycles;
    int                send_gap_pct;
    int                recv_stall_pct;
    string             mismatch_detail;

    text_console_number_writer_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Prints one line per mismatch and counts it.
    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t:%s", $realtime, msg);
        err_count++;
    endtask

    // Presents one beat on the input stream after a random number of idle cycles
    // and returns at the edge where it is taken. tvalid stays high afterwards, so
    // back-to-back beats need no low cycle between them.
    task automatic send_item(input logic [FUNC_W-1:0] f, input logic [CHAR_W-1:0] ch,
                             input logic [NUM_W-1:0] num);
        @(negedge clk);
        while ($urandom_range(99) < send_gap_pct)
        begin
            s_tvalid = 1'b0;
            @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tuser  = f;
        s_tdata  = {num, ch};
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_item(f, ch, num);
    endtask

    // Registers change only while the writer is idle: every owed cell write has
    // been seen, and then enough cycles have passed for a trailing cursor move.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [PAD_W-1:0] val);
        @(negedge clk);
        s_tvalid = 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.write_reg(idx, val);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // The receiver stalls at random, one decision per cycle.
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            m_tready = ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Every output beat is checked against the oldest cell write still owed.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (sb.pending.size() == 0)
                report_mismatch($sformatf(" unexpected cell write at %0d, glyph %02h",
                                          m_tdata[10:0], m_tdata[18:11]));
            else if (!sb.check_write(m_tdata[10:0], m_tdata[18:11], m_tlast, mismatch_detail))
                report_mismatch(mismatch_detail);
        end
    end

    // The watchdog counts cycles in which no beat moves on any channel. The
    // longest legal quiet stretch is a config drain or a decimal conversion
    // followed by a long receiver stall, far below the limit.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("text_console_number_writer_top_tb failed");
            $finish;
        end
    end

    initial
    begin
        int               pass;
        int               seg;
        int               sent;
        int               pick;
        logic [FUNC_W-1:0] f;
        logic [CHAR_W-1:0] ch;
        logic [NUM_W-1:0]  num;
        logic [PAD_W-1:0]  val;

        sb             = new();
        err_count      = 0;
        quiet_cycles   = 0;
        send_gap_pct   = 30;
        recv_stall_pct = 81;
        rst_n          = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = FUNC_CHAR;
        cfg_valid      = 1'b0;
        cfg_index      = REG_BASE;
        cfg_data       = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part at the reset setting (decimal, no padding): character
        // bytes at both ends of the range, each control character, numbers at
        // both ends, pointers, and an unused function code that must be ignored.
        send_item(FUNC_CHAR, 8'h48, 32'h0);
        send_item(FUNC_CHAR, 8'h00, 32'hFFFF_FFFF);
        send_item(FUNC_CHAR, 8'hFF, 32'h0);
        send_item(FUNC_CHAR, CH_TAB, 32'h0);
        send_item(FUNC_CHAR, CH_CR, 32'h0);
        send_item(FUNC_CHAR, CH_LF, 32'h0);
        send_item(FUNC_NUM, 8'hFF, 32'h0);
        send_item(FUNC_NUM, 8'h00, 32'hFFFF_FFFF);
        send_item(FUNC_PTR, 8'h00, 32'h0);
        send_item(FUNC_PTR, 8'h00, 32'hFFFF_FFFF);
        send_item(FUNC_UNUSED, 8'h41, 32'h1234_5678);

        // Binary with a pad width above the digit capacity, which saturates.
        write_reg(REG_BASE, {4'b0000, BASE_BIN});
        write_reg(REG_PAD, 6'd63);
        send_item(FUNC_NUM, 8'h00, 32'h0);
        send_item(FUNC_NUM, 8'h00, 32'hFFFF_FFFF);

        // The unused base code prints hexadecimal; upper data bits are don't-care.
        write_reg(REG_BASE, {4'b1111, BASE_ALIAS});
        write_reg(REG_PAD, 6'd5);
        send_item(FUNC_NUM, 8'h00, 32'h0000_0ABC);
        send_item(FUNC_NUM, 8'h00, 32'hFEDC_BA98);

        // Hexadecimal at the full pad width.
        write_reg(REG_BASE, {4'b0000, BASE_HEX});
        write_reg(REG_PAD, 6'd32);
        send_item(FUNC_NUM, 8'h00, 32'h1);
        send_item(FUNC_PTR, 8'h00, 32'h1234_ABCD);

        write_reg(REG_PAD, 6'd0);
        write_reg(REG_BASE, {4'b0000, BASE_BIN});
        send_item(FUNC_NUM, 8'h00, 32'h0);
        send_item(FUNC_NUM, 8'h00, 32'h8000_0000);

        // Writes to unmapped indexes must leave both registers alone.
        write_reg(REG_SPARE2, 6'h2A);
        write_reg(REG_SPARE3, 6'h15);
        send_item(FUNC_NUM, 8'h00, 32'h0000_0005);
        write_reg(REG_BASE, {4'b0000, BASE_DEC});
        write_reg(REG_PAD, 6'd12);
        send_item(FUNC_NUM, 8'h00, 32'd12345);

        // Random part in three passes: sender idles 30 and receiver 81 percent,
        // then the reverse, then neither idles. Each pass is cut into segments,
        // and every segment starts with a fresh register setting.
        for (pass = 0; pass < 3; pass++)
        begin
            send_gap_pct   = (pass == 0) ? 30 : (pass == 1) ? 81 : 0;
            recv_stall_pct = (pass == 0) ? 81 : (pass == 1) ? 30 : 0;
            for (seg = 0; seg < SEGS_PER_PASS; seg++)
            begin
                val = {4'($urandom_range(15)), 2'($urandom_range(3))};
                write_reg(REG_BASE, val);
                val = ($urandom_range(1) == 0) ? 6'($urandom_range(12)) :
                                                 6'($urandom_range(63));
                write_reg(REG_PAD, val);
                sent = 0;
                while (sent < SEG_ITEMS)
                begin
                    ch   = 8'($urandom);
                    pick = $urandom_range(3);
                    num  = (pick == 0) ? 32'($urandom) :
                           (pick == 1) ? 32'($urandom_range(255)) :
                           (pick == 2) ? (32'hFFFF_FFFF >> $urandom_range(31)) :
                                         (32'h1 << $urandom_range(31));
                    pick = $urandom_range(99);
                    if (pick < 45)
                    begin
                        f = FUNC_CHAR;
                        // A quarter of the characters are cursor moves, which
                        // also drive the cursor through the end of the screen.
                        if ($urandom_range(3) == 0)
                        begin
                            pick = $urandom_range(2);
                            ch = (pick == 0) ? CH_LF : (pick == 1) ? CH_TAB : CH_CR;
                        end
                    end
                    else if (pick < 72)
                        f = FUNC_NUM;
                    else if (pick < 95)
                        f = FUNC_PTR;
                    else
                        f = FUNC_UNUSED;
                    send_item(f, ch, num);
                    if (f != FUNC_UNUSED)
                        sent++;
                end
            end
        end

        // Drain: the last beats must all arrive, and nothing may follow them.
        @(negedge clk);
        s_tvalid = 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (err_count == 0)
            $display("text_console_number_writer_top_tb passed");
        else
            $display("text_console_number_writer_top_tb failed");
        $finish;
    end

endmodule
